### rtl/core/rwd_pkg.sv
// Package for the ROM word decryptor: bit permutation, address swap,
// S-box and final XOR word tables, plus the per-step helper functions.
// No dependencies.
package rwd_pkg;

    typedef logic [3:0]  nib_t;
    typedef logic [4:0]  quint_t;
    typedef logic [2:0]  tri_t;
    typedef logic [15:0] word_t;
    typedef logic [7:0]  key_t;

    // APB register map: one register, word aligned
    localparam int unsigned PADDR_W  = 3;
    localparam int unsigned PDATA_W  = 32;
    localparam logic        REG_KEY  = 1'b0;

    // Ciphertext permutations: output bit j takes input bit PERM_TAB[s][j]
    localparam nib_t PERM_TAB [4][16] = '{
        '{4'd14, 4'd1,  4'd11, 4'd15, 4'd7,  4'd3,  4'd8,  4'd13,
          4'd0,  4'd4,  4'd2,  4'd12, 4'd6,  4'd10, 4'd5,  4'd9},
        '{4'd8,  4'd10, 4'd1,  4'd3,  4'd7,  4'd4,  4'd11, 4'd2,
          4'd5,  4'd15, 4'd6,  4'd0,  4'd12, 4'd13, 4'd9,  4'd14},
        '{4'd4,  4'd5,  4'd9,  4'd6,  4'd1,  4'd13, 4'd7,  4'd11,
          4'd10, 4'd0,  4'd14, 4'd12, 4'd8,  4'd15, 4'd2,  4'd3},
        '{4'd12, 4'd7,  4'd11, 4'd2,  4'd0,  4'd5,  4'd15, 4'd6,
          4'd1,  4'd8,  4'd14, 4'd4,  4'd9,  4'd13, 4'd3,  4'd10}
    };

    // Address swap: output bit (15 - i) takes address bit ADDR_SRC[i]
    localparam nib_t ADDR_SRC [16] = '{
        4'd13, 4'd5, 4'd2, 4'd14, 4'd10, 4'd9, 4'd4, 4'd15,
        4'd11, 4'd6, 4'd1, 4'd12, 4'd8,  4'd7, 4'd3, 4'd0
    };

    localparam quint_t SB5 [4][32] = '{
        '{5'd11, 5'd8,  5'd6,  5'd25, 5'd2,  5'd7,  5'd23, 5'd28,
          5'd5,  5'd10, 5'd21, 5'd20, 5'd1,  5'd26, 5'd17, 5'd19,
          5'd14, 5'd27, 5'd22, 5'd30, 5'd15, 5'd4,  5'd9,  5'd24,
          5'd31, 5'd3,  5'd16, 5'd12, 5'd0,  5'd18, 5'd29, 5'd13},
        '{5'd9,  5'd15, 5'd28, 5'd7,  5'd13, 5'd24, 5'd2,  5'd23,
          5'd21, 5'd1,  5'd22, 5'd16, 5'd18, 5'd8,  5'd17, 5'd31,
          5'd27, 5'd6,  5'd30, 5'd12, 5'd4,  5'd20, 5'd5,  5'd19,
          5'd0,  5'd25, 5'd3,  5'd29, 5'd10, 5'd14, 5'd11, 5'd26},
        '{5'd17, 5'd25, 5'd29, 5'd27, 5'd5,  5'd11, 5'd10, 5'd21,
          5'd2,  5'd8,  5'd13, 5'd0,  5'd30, 5'd3,  5'd14, 5'd16,
          5'd22, 5'd1,  5'd7,  5'd15, 5'd31, 5'd18, 5'd4,  5'd20,
          5'd9,  5'd19, 5'd26, 5'd24, 5'd23, 5'd28, 5'd12, 5'd6},
        '{5'd7,  5'd21, 5'd9,  5'd20, 5'd10, 5'd28, 5'd31, 5'd11,
          5'd16, 5'd15, 5'd14, 5'd30, 5'd27, 5'd23, 5'd5,  5'd25,
          5'd0,  5'd22, 5'd24, 5'd2,  5'd6,  5'd17, 5'd3,  5'd18,
          5'd4,  5'd12, 5'd13, 5'd19, 5'd26, 5'd1,  5'd29, 5'd8}
    };

    localparam nib_t SB4A [4][16] = '{
        '{4'd13, 4'd5, 4'd9,  4'd6,  4'd4,  4'd2,  4'd11, 4'd10,
          4'd12, 4'd0, 4'd8,  4'd1,  4'd3,  4'd14, 4'd15, 4'd7},
        '{4'd5,  4'd2, 4'd13, 4'd11, 4'd8,  4'd6,  4'd12, 4'd1,
          4'd4,  4'd3, 4'd0,  4'd10, 4'd14, 4'd15, 4'd7,  4'd9},
        '{4'd15, 4'd3, 4'd2,  4'd11, 4'd7,  4'd14, 4'd6,  4'd12,
          4'd1,  4'd13, 4'd0, 4'd8,  4'd9,  4'd4,  4'd10, 4'd5},
        '{4'd10, 4'd6, 4'd5,  4'd1,  4'd13, 4'd0,  4'd9,  4'd2,
          4'd15, 4'd14, 4'd7, 4'd11, 4'd8,  4'd3,  4'd12, 4'd4}
    };

    localparam nib_t SB4B [4][16] = '{
        '{4'd1,  4'd13, 4'd11, 4'd3,  4'd8,  4'd7,  4'd9,  4'd10,
          4'd12, 4'd15, 4'd4,  4'd14, 4'd0,  4'd5,  4'd6,  4'd2},
        '{4'd11, 4'd6,  4'd10, 4'd0,  4'd12, 4'd1,  4'd8,  4'd14,
          4'd2,  4'd9,  4'd13, 4'd3,  4'd7,  4'd4,  4'd15, 4'd5},
        '{4'd6,  4'd12, 4'd5,  4'd7,  4'd4,  4'd8,  4'd2,  4'd3,
          4'd1,  4'd14, 4'd13, 4'd11, 4'd9,  4'd10, 4'd0,  4'd15},
        '{4'd8,  4'd6,  4'd15, 4'd13, 4'd2,  4'd7,  4'd1,  4'd3,
          4'd11, 4'd0,  4'd14, 4'd10, 4'd4,  4'd5,  4'd12, 4'd9}
    };

    localparam tri_t SB3 [4][8] = '{
        '{3'd3, 3'd0, 3'd5, 3'd6, 3'd2, 3'd4, 3'd1, 3'd7},
        '{3'd1, 3'd5, 3'd6, 3'd2, 3'd4, 3'd7, 3'd3, 3'd0},
        '{3'd5, 3'd1, 3'd0, 3'd3, 3'd4, 3'd6, 3'd2, 3'd7},
        '{3'd6, 3'd5, 3'd4, 3'd1, 3'd0, 3'd2, 3'd3, 3'd7}
    };

    // Final XOR words; entries with no known word are all ones
    localparam word_t XOR_WORDS [16] = '{
        16'h0000, 16'hFFFF, 16'h97CF, 16'h4BE3,
        16'h2255, 16'h8DD6, 16'hFFFF, 16'hC6A2,
        16'hA1E8, 16'hB3BF, 16'h3B1A, 16'h547A,
        16'hFFFF, 16'h935F, 16'hFFFF, 16'hFFFF
    };

    // Permute the ciphertext bits with the selected table
    function automatic word_t permute(input word_t cw, input logic [1:0] sel);
        word_t res;
        res = '0;
        for (int j = 0; j < 16; j++)
        begin
            res[j] = cw[PERM_TAB[sel][j]];
        end
        return res;
    endfunction

    // Fixed bit swap of the word address
    function automatic word_t addr_swap(input word_t addr);
        word_t res;
        res = '0;
        for (int j = 0; j < 16; j++)
        begin
            res[15 - j] = addr[ADDR_SRC[j]];
        end
        return res;
    endfunction

    // Substitute the four fields through the selected S-box set
    function automatic word_t substitute(input word_t aux, input logic [1:0] set);
        quint_t b0;
        nib_t   b1;
        nib_t   b2;
        tri_t   b3;
        b0 = SB5[set][aux[4:0]];
        b1 = SB4A[set][aux[8:5]];
        b2 = SB4B[set][aux[12:9]];
        b3 = SB3[set][aux[15:13]];
        return {b3, b2, b1, b0};
    endfunction

endpackage

### rtl/core/rwd_ifs.sv
// Request channels of the ROM word decryptor: ciphertext in, plaintext out.
// Depends on nothing.
interface rwd_cipher_if;
    logic        valid;
    logic        ready;
    logic [15:0] cipher_word;
    logic [15:0] word_address;

    modport source (output valid, output cipher_word, output word_address, input ready);
    modport sink   (input valid, input cipher_word, input word_address, output ready);
endinterface

interface rwd_plain_if;
    logic        valid;
    logic        ready;
    logic [15:0] plain_word;

    modport source (output valid, output plain_word, input ready);
    modport sink   (input valid, input plain_word, output ready);
endinterface

### rtl/core/rom_word_decrypt_unit.sv
// ROM word decryptor top level: input register, decrypt logic, result register.
// Depends on rwd_pkg and the channel interfaces in rwd_ifs.sv.
// Path: an accepted word passes the input register, then the result register, before
// plain.valid rises. Throughput: one word per cycle while plain.ready does not stall the
// result register; permutation, S-box and XOR logic form a single pass between registers.
// Reset: rst_n clears both valid flags and the key register to zero.
module rom_word_decrypt_unit
    import rwd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    rwd_cipher_if.sink           cipher,
    rwd_plain_if.source          plain,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready
);

    key_t   key_reg;
    key_t   key_next;
    logic   cfg_wr;

    logic   s1_valid_reg;
    word_t  s1_word_reg;
    word_t  s1_addr_reg;
    logic   s1_advance;

    logic   out_valid_reg;
    word_t  out_word_reg;
    word_t  dec_word;

    // Configuration port: write the key on the access phase
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        key_next = key_reg;
        if (cfg_wr && (paddr[2] == REG_KEY))
        begin
            key_next = pwdata[7:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_KEY)
        begin
            prdata = {{(PDATA_W - 8){1'b0}}, key_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
        end
        else
        begin
            key_reg <= key_next;
        end
    end

    // Stall control: each stage advances when the next one frees up
    assign s1_advance   = !out_valid_reg || plain.ready;
    assign cipher.ready = !s1_valid_reg || s1_advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cipher.ready)
            begin
                s1_valid_reg <= cipher.valid;
            end
            if (s1_advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Hold the incoming request
    always_ff @(posedge clk)
    begin
        if (cipher.ready && cipher.valid)
        begin
            s1_word_reg <= cipher.cipher_word;
            s1_addr_reg <= cipher.word_address;
        end
    end

    // Decrypt: permute, mix in swapped address, substitute, final XOR
    always_comb
    begin
        word_t aux;
        aux      = permute(s1_word_reg, key_reg[7:6]) ^ addr_swap(s1_addr_reg);
        dec_word = substitute(aux, key_reg[5:4]) ^ XOR_WORDS[key_reg[3:0]];
    end

    // Hold the result until taken
    always_ff @(posedge clk)
    begin
        if (s1_advance && s1_valid_reg)
        begin
            out_word_reg <= dec_word;
        end
    end

    assign plain.valid      = out_valid_reg;
    assign plain.plain_word = out_word_reg;

`ifndef ASSERT_OFF
    a_stage_fill: assert property (@(posedge clk) disable iff (!rst_n)
        cipher.valid && cipher.ready |=> s1_valid_reg)
        else $error("accepted request did not reach the input register");

    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_advance |=> plain.valid && (plain.plain_word == $past(dec_word)))
        else $error("decrypted word not presented after advance");

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_advance |=> s1_valid_reg && $stable(s1_word_reg)
            && $stable(s1_addr_reg))
        else $error("stalled input register lost its request");

    a_key_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr && (paddr[2] == REG_KEY) |=> key_reg == $past(pwdata[7:0]))
        else $error("key register write not taken");
`endif

endmodule
